// ----- rtl/core/hpd_pkg.sv -----
// Package for the heading PD fan controller: transaction payload types,
// configuration register map, register set struct and compass constants.
// No dependencies.
`default_nettype none

package hpd_pkg;

   // Compass circle in tenths of a degree
   localparam logic signed [12:0] HALF_TURN = 13'sd1800;
   localparam logic signed [12:0] FULL_TURN = 13'sd3600;

   localparam logic signed [11:0] LAST_ERROR_RESET = 12'sd20;

   // Configuration port geometry
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (byte address is 4 times the index)
   localparam logic [2:0] REG_TARGET_HEADING    = 3'd0;
   localparam logic [2:0] REG_PROP_GAIN         = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN        = 3'd2;
   localparam logic [2:0] REG_NEUTRAL_WIDTH     = 3'd3;
   localparam logic [2:0] REG_DERIV_THRESHOLD   = 3'd4;
   localparam logic [2:0] REG_DRIVE_LIMIT       = 3'd5;
   localparam logic [2:0] REG_OBSTACLE_DISTANCE = 3'd6;
   localparam logic [2:0] REG_AVOID_HEADING     = 3'd7;

   typedef enum logic {
      OP_HEADING = 1'b0,
      OP_RANGE   = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [11:0] heading_sample;
      logic [15:0] range_sample;
   } req_type;

   typedef struct packed {
      logic signed [10:0] drive;
      logic [15:0]        rudder_width;
      logic [15:0]        left_width;
      logic [15:0]        right_width;
   } rsp_type;

   typedef struct packed {
      logic [11:0] target_heading;
      logic [7:0]  prop_gain;
      logic [7:0]  deriv_gain;
      logic [15:0] neutral_width;
      logic [11:0] deriv_threshold;
      logic [9:0]  drive_limit;
      logic [15:0] obstacle_distance;
      logic [11:0] avoid_heading;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_heading:    12'd1800,
      prop_gain:         8'd2,
      deriv_gain:        8'd50,
      neutral_width:     16'd2765,
      deriv_threshold:   12'd100,
      drive_limit:       10'd737,
      obstacle_distance: 16'd50,
      avoid_heading:     12'd2700
   };

endpackage

`default_nettype wire

// ----- rtl/core/heading_pd_fan_controller_top.sv -----
// Heading PD fan controller. A compass sample goes from the input register
// through the law to the output register; one transaction per cycle unless
// a stalled result holds a compass sample. A ranger sample yields no result.
// The rate is set by the single law stage between input and result registers.
// Reset (synchronous): registers to defaults, last error 20, target in use.
// Depends on hpd_pkg, hpd_csr and hpd_law.
`default_nettype none

module heading_pd_fan_controller_top
   import hpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type            cfg;
   logic               in_valid_ff, in_valid_in;
   req_type            in_item_ff, in_item_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic signed [11:0] last_error_ff, last_error_in;
   logic               avoiding_ff, avoiding_in;
   logic signed [11:0] law_error;
   rsp_type            law_result;
   logic               out_free;
   logic               advance;
   logic               is_range;

   hpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hpd_law u_law (
      .cfg            (cfg),
      .avoiding       (avoiding_ff),
      .last_error     (last_error_ff),
      .heading_sample (in_item_ff.heading_sample),
      .error          (law_error),
      .result         (law_result)
   );

   assign is_range  = (in_item_ff.op == OP_RANGE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // ranger transactions retire without touching the result register
   assign advance   = in_valid_ff && (is_range || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in   = req_ready ? req_valid : in_valid_ff;
      in_item_in    = (req_valid && req_ready) ? req_data : in_item_ff;
      rsp_valid_in  = out_free ? (advance && !is_range) : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      last_error_in = last_error_ff;
      avoiding_in   = avoiding_ff;
      if (advance && !is_range) begin
         rsp_data_in   = law_result;
         last_error_in = law_error;
      end
      if (advance && is_range) begin
         avoiding_in = (in_item_ff.range_sample <= cfg.obstacle_distance);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_error_ff <= LAST_ERROR_RESET;
         avoiding_ff   <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_error_ff <= last_error_in;
         avoiding_ff   <= avoiding_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/hpd_csr.sv -----
// Configuration register file on an APB-style port.
// Depends on hpd_pkg for the register map and the register set struct.
`default_nettype none

module hpd_csr
   import hpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_TARGET_HEADING:    cfg_in.target_heading    = pwdata[11:0];
            REG_PROP_GAIN:         cfg_in.prop_gain         = pwdata[7:0];
            REG_DERIV_GAIN:        cfg_in.deriv_gain        = pwdata[7:0];
            REG_NEUTRAL_WIDTH:     cfg_in.neutral_width     = pwdata[15:0];
            REG_DERIV_THRESHOLD:   cfg_in.deriv_threshold   = pwdata[11:0];
            REG_DRIVE_LIMIT:       cfg_in.drive_limit       = pwdata[9:0];
            REG_OBSTACLE_DISTANCE: cfg_in.obstacle_distance = pwdata[15:0];
            REG_AVOID_HEADING:     cfg_in.avoid_heading     = pwdata[11:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_TARGET_HEADING:    prdata = {20'd0, cfg_ff.target_heading};
         REG_PROP_GAIN:         prdata = {24'd0, cfg_ff.prop_gain};
         REG_DERIV_GAIN:        prdata = {24'd0, cfg_ff.deriv_gain};
         REG_NEUTRAL_WIDTH:     prdata = {16'd0, cfg_ff.neutral_width};
         REG_DERIV_THRESHOLD:   prdata = {20'd0, cfg_ff.deriv_threshold};
         REG_DRIVE_LIMIT:       prdata = {22'd0, cfg_ff.drive_limit};
         REG_OBSTACLE_DISTANCE: prdata = {16'd0, cfg_ff.obstacle_distance};
         REG_AVOID_HEADING:     prdata = {20'd0, cfg_ff.avoid_heading};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/hpd_law.sv -----
// Control law for one compass sample: wrapped heading error, gated
// derivative term, clamp and fan pulse widths. Depends on hpd_pkg.
`default_nettype none

module hpd_law
   import hpd_pkg::*;
(
   input  wire cfg_type            cfg,
   input  wire logic               avoiding,
   input  wire logic signed [11:0] last_error,
   input  wire logic [11:0]        heading_sample,
   output logic signed [11:0]      error,
   output rsp_type                 result
);

   logic [11:0]        target;
   logic signed [12:0] raw_error;
   logic signed [12:0] wrapped;
   logic signed [12:0] diff;
   logic [11:0]        mag;
   logic               use_deriv;
   logic signed [20:0] p_term;
   logic signed [21:0] d_term;
   logic signed [22:0] sum;
   logic signed [22:0] limit;
   logic signed [22:0] clamped;
   logic [15:0]        drive_ext;

   always_comb begin
      target    = avoiding ? cfg.avoid_heading : cfg.target_heading;
      raw_error = $signed({1'b0, target}) - $signed({1'b0, heading_sample});

      // one wrap step brings the error back onto the half circle
      if (raw_error > HALF_TURN) begin
         wrapped = raw_error - FULL_TURN;
      end else if (raw_error < -HALF_TURN) begin
         wrapped = raw_error + FULL_TURN;
      end else begin
         wrapped = raw_error;
      end
      error = wrapped[11:0];

      diff      = $signed({error[11], error}) - $signed({last_error[11], last_error});
      mag       = diff[12] ? 12'(-diff) : diff[11:0];
      use_deriv = mag > cfg.deriv_threshold;

      p_term = $signed({1'b0, cfg.prop_gain}) * error;
      d_term = $signed({1'b0, cfg.deriv_gain}) * diff;
      sum    = 23'(p_term);
      if (use_deriv) begin
         sum = sum + 23'(d_term);
      end

      limit = $signed({13'd0, cfg.drive_limit});
      if (sum > limit) begin
         clamped = limit;
      end else if (sum < -limit) begin
         clamped = -limit;
      end else begin
         clamped = sum;
      end

      result.drive        = clamped[10:0];
      drive_ext           = {{5{clamped[10]}}, clamped[10:0]};
      result.left_width   = cfg.neutral_width + drive_ext;
      result.right_width  = cfg.neutral_width - drive_ext;
      result.rudder_width = result.right_width;
   end

endmodule

`default_nettype wire

// ----- rtl/core/hpd_checker.sv -----
// Port-level checker for the heading PD fan controller, bound to the top.
// Depends on hpd_pkg and heading_pd_fan_controller_top.
`default_nettype none

module hpd_checker
   import hpd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input side backs up only behind a stalled result
   a_req_block: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("handshake not idle after reset");

   a_rudder_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.rudder_width == rsp_data.right_width)
      else $error("rudder and right widths disagree");

endmodule

bind heading_pd_fan_controller_top hpd_checker u_hpd_checker (.*);

`default_nettype wire

// ----- bench/heading_pd_fan_controller_top_tb.sv -----
// Testbench for heading_pd_fan_controller_top: checks fan widths and drive per compass sample
// against a scoreboard that tracks error history, avoidance and register settings.
// Depends on hpd_pkg and the RTL of the controller.
`timescale 1ns / 1ps

module heading_pd_fan_controller_top_tb;
   import hpd_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 93;

   class steering_check;
      cfg_type            settings;
      logic signed [11:0] heading_error;
      bit                 avoiding_obstacle;
      rsp_type            expected_cmds[$];
      int                 failures;

      function new();
         settings = CFG_RESET;
         heading_error = LAST_ERROR_RESET;
         avoiding_obstacle = 1'b0;
         failures = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_TARGET_HEADING:    settings.target_heading = value[11:0];
            REG_PROP_GAIN:         settings.prop_gain = value[7:0];
            REG_DERIV_GAIN:        settings.deriv_gain = value[7:0];
            REG_NEUTRAL_WIDTH:     settings.neutral_width = value[15:0];
            REG_DERIV_THRESHOLD:   settings.deriv_threshold = value[11:0];
            REG_DRIVE_LIMIT:       settings.drive_limit = value[9:0];
            REG_OBSTACLE_DISTANCE: settings.obstacle_distance = value[15:0];
            REG_AVOID_HEADING:     settings.avoid_heading = value[11:0];
            default: ;
         endcase
      endfunction

      // Work out the fan command caused by one accepted sample.
      function void take_sample(req_type s);
         int aim, h, err, prev, delta, mag, level, lim, pg, dg;
         rsp_type cmd;
         if (s.op == OP_RANGE) begin
            avoiding_obstacle = (s.range_sample <= settings.obstacle_distance);
            return;
         end
         aim = avoiding_obstacle ? int'(settings.avoid_heading)
                                 : int'(settings.target_heading);
         h = int'(s.heading_sample);
         err = aim - h;
         if (err > 1800)
            err = err - 3600;
         else if (err < -1800)
            err = err + 3600;
         prev = int'(heading_error);
         delta = err - prev;
         mag = (delta < 0) ? -delta : delta;
         pg = int'(settings.prop_gain);
         dg = int'(settings.deriv_gain);
         level = pg * err;
         if (mag > int'(settings.deriv_threshold))
            level = level + dg * delta;
         heading_error = err[11:0];
         lim = int'(settings.drive_limit);
         if (level > lim)
            level = lim;
         if (level < -lim)
            level = -lim;
         cmd.drive = level[10:0];
         cmd.rudder_width = settings.neutral_width - level[15:0];
         cmd.left_width = settings.neutral_width + level[15:0];
         cmd.right_width = settings.neutral_width - level[15:0];
         expected_cmds.push_back(cmd);
      endfunction

      function void check_command(rsp_type got);
         rsp_type want;
         if (expected_cmds.size() == 0) begin
            $error("fan command with no compass sample pending: drive %0d", $signed(got.drive));
            failures++;
            return;
         end
         want = expected_cmds.pop_front();
         if (got.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(got.drive));
            failures++;
         end
         if (got.rudder_width !== want.rudder_width) begin
            $error("rudder_width: expected %0d, got %0d", want.rudder_width, got.rudder_width);
            failures++;
         end
         if (got.left_width !== want.left_width) begin
            $error("left_width: expected %0d, got %0d", want.left_width, got.left_width);
            failures++;
         end
         if (got.right_width !== want.right_width) begin
            $error("right_width: expected %0d, got %0d", want.right_width, got.right_width);
            failures++;
         end
      endfunction

      function int pending();
         return expected_cmds.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;
   bit rsp_hold = 1'b0;
   logic [11:0] last_heading = 12'd0;

   steering_check sb = new();

   heading_pd_fan_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.take_sample(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_command(rsp_data);
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int unsigned stall;
      rsp_ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end else begin
            stall = receiver_idle ? $urandom_range(14, 0) : 0;
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid && !rsp_hold);
         @(posedge clock);
      end
   end

   // Leaves valid high after acceptance; the caller drops it.
   task automatic send_item(input req_type it);
      int unsigned gap;
      gap = sender_idle ? $urandom_range(14, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic send_heading(input logic [11:0] h);
      req_type it;
      it.op = OP_HEADING;
      it.heading_sample = h;
      it.range_sample = 16'($urandom_range(65535, 0));
      send_item(it);
   endtask

   task automatic send_range(input logic [15:0] r);
      req_type it;
      it.op = OP_RANGE;
      it.heading_sample = 12'($urandom_range(4095, 0));
      it.range_sample = r;
      send_item(it);
   endtask

   // Leaves psel high; load_settings closes the sequence.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      sb.write_register(index, value);
   endtask

   task automatic load_settings(input cfg_type c);
      csr_write(REG_TARGET_HEADING, 32'(c.target_heading));
      csr_write(REG_PROP_GAIN, 32'(c.prop_gain));
      csr_write(REG_DERIV_GAIN, 32'(c.deriv_gain));
      csr_write(REG_NEUTRAL_WIDTH, 32'(c.neutral_width));
      csr_write(REG_DERIV_THRESHOLD, 32'(c.deriv_threshold));
      csr_write(REG_DRIVE_LIMIT, 32'(c.drive_limit));
      csr_write(REG_OBSTACLE_DISTANCE, 32'(c.obstacle_distance));
      csr_write(REG_AVOID_HEADING, 32'(c.avoid_heading));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Wait out every pending command, then the pipeline behind a ranger sample.
   task automatic settle();
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      c.target_heading = 12'($urandom_range(3599, 0));
      if ($urandom_range(3, 0) == 0)
         c.target_heading = 12'($urandom_range(4095, 3600));
      c.avoid_heading = 12'($urandom_range(3599, 0));
      if ($urandom_range(3, 0) == 0)
         c.avoid_heading = 12'($urandom_range(4095, 3600));
      // keep the gains low half the time so the drive often stays unclamped
      c.prop_gain = $urandom_range(1, 0) ? 8'($urandom_range(3, 0))
                                         : 8'($urandom_range(255, 0));
      c.deriv_gain = $urandom_range(1, 0) ? 8'($urandom_range(3, 0))
                                          : 8'($urandom_range(255, 0));
      c.neutral_width = $urandom_range(3, 0) ? 16'($urandom_range(64798, 737))
                                             : 16'($urandom_range(65535, 0));
      c.deriv_threshold = $urandom_range(1, 0) ? 12'($urandom_range(400, 0))
                                               : 12'($urandom_range(4095, 0));
      c.drive_limit = $urandom_range(3, 0) ? 10'($urandom_range(737, 0))
                                           : 10'($urandom_range(1023, 738));
      c.obstacle_distance = 16'($urandom_range(65535, 0));
      return c;
   endfunction

   function automatic req_type make_item();
      req_type it;
      int unsigned pick;
      it.op = ($urandom_range(99, 0) < 35) ? OP_RANGE : OP_HEADING;
      pick = $urandom_range(9, 0);
      if (pick < 6)
         it.heading_sample = 12'($urandom_range(3599, 0));
      else if (pick == 6)
         it.heading_sample = 12'($urandom_range(4095, 3600));
      else if (pick == 7)
         it.heading_sample = $urandom_range(1, 0) ? 12'd0 : 12'd3599;
      else
         // small step from the last heading keeps the error change small
         it.heading_sample = 12'((last_heading + $urandom_range(40, 0) + 3580) % 3600);
      if (it.op == OP_HEADING)
         last_heading = it.heading_sample;
      pick = $urandom_range(7, 0);
      if (pick < 3)
         it.range_sample = 16'($urandom_range(65535, 0));
      else if (pick == 3)
         it.range_sample = sb.settings.obstacle_distance;
      else if (pick == 4)
         it.range_sample = sb.settings.obstacle_distance + 16'd1;
      else if (pick == 5)
         it.range_sample = sb.settings.obstacle_distance - 16'd1;
      else
         it.range_sample = (pick == 6) ? 16'd0 : 16'hFFFF;
      return it;
   endfunction

   initial begin
      cfg_type c;
      req_valid <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: wrap edges, clamps, derivative gate, avoidance switch.
      send_heading(12'd1800);
      send_heading(12'd1780);
      send_heading(12'd1650);
      send_heading(12'd1810);
      send_heading(12'd0);
      send_heading(12'd3599);
      send_heading(12'd4095);
      send_heading(12'd3600);
      send_heading(12'd3601);
      send_range(16'd51);
      send_heading(12'd0);
      send_range(16'd50);
      send_heading(12'd0);
      send_heading(12'd900);
      send_heading(12'd4095);
      send_range(16'd0);
      send_heading(12'd2700);
      send_range(16'hFFFF);
      send_heading(12'd2700);
      send_heading(12'd2048);
      send_heading(12'd1365);
      send_heading(12'd2730);
      send_range(16'hAAAA);
      send_range(16'h5555);
      req_valid <= 1'b0;
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: c = '0;
            1: c = '1;
            2: begin
               c = random_settings();
               c.neutral_width = 16'd0;
               c.drive_limit = 10'd737;
            end
            3: begin
               c = random_settings();
               c.neutral_width = 16'hFFFF;
               c.drive_limit = 10'd737;
            end
            default: c = random_settings();
         endcase
         load_settings(c);
         sender_idle = (ph % 3 != 1);
         receiver_idle = (ph % 4 != 2);
         if (ph == 4) begin
            // fill the block behind a long result stall
            sender_idle = 1'b0;
            rsp_hold = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 5 && n == 40) begin
               req_valid <= 1'b0;
               settle();
            end
            send_item(make_item());
         end
         req_valid <= 1'b0;
         settle();
      end

      if (sb.failures == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
